[src/pwbd_pkg.sv]
// Shared types and constants for the pulse-width bit decoder.
package pwbd_pkg;

    // Width of the decoded word port and of the threshold register
    localparam int unsigned DATA_WIDTH      = 8;
    localparam int unsigned THRESH_WIDTH    = 32;
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 32'd5000;

    // Outcome of decoding one line sample
    typedef struct packed {
        logic                  emit;
        logic [DATA_WIDTH-1:0] data;
    } pwbd_result_t;

endpackage

[src/pulse_width_bit_decoder.sv]
// Pulse-width bit decoder top level: sample register, decoder core, byte output register.
//
// One line sample per request, one request per cycle sustained unless the output stalls.
// Each sample is held in an input register, decoded combinationally by the core, and a
// finished byte lands in an output register. The input side keeps taking samples while a
// byte waits, stalling only when a new byte must be written while the previous one is
// still untaken. The threshold is a high time in ticks: a pulse strictly longer than it
// decodes as 0, otherwise 1; first bit lands in the MSB.
module pulse_width_bit_decoder #(
    parameter int unsigned BITS_PER_WORD = 8,
    parameter int unsigned COUNT_WIDTH   = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic                                line_level,
    output logic                                byte_valid,
    input  logic                                byte_ready,
    output logic [pwbd_pkg::DATA_WIDTH-1:0]     data_byte,
    output logic                                last,
    input  logic                                cfg_we,
    input  logic [pwbd_pkg::THRESH_WIDTH-1:0]   cfg_wdata
);
    import pwbd_pkg::*;

    logic [THRESH_WIDTH-1:0] threshold_reg;
    logic                    in_valid_reg, in_valid_next;
    logic                    level_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0]   out_data_reg;
    logic                    out_free;
    logic                    advance;
    logic                    load_out;
    pwbd_result_t            result;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    pwbd_core #(
        .BITS_PER_WORD (BITS_PER_WORD),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .level     (level_reg),
        .threshold (threshold_reg),
        .result    (result)
    );

    // Flow control: a held sample moves on unless it makes a byte with no room for it
    assign out_free     = !out_valid_reg || byte_ready;
    assign advance      = in_valid_reg && (out_free || !result.emit);
    assign load_out     = advance && result.emit;
    assign sample_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = (in_valid_reg && !advance) || (sample_valid && sample_ready);
        out_valid_next = load_out || (out_valid_reg && !byte_ready);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            level_reg <= line_level;
        end
        if (load_out)
        begin
            out_data_reg <= result.data;
        end
    end

    assign byte_valid = out_valid_reg;
    assign data_byte  = out_data_reg;
    assign last       = 1'b1;

endmodule

[src/pwbd_core.sv]
// Decoder state and per-sample next-state logic: edge detect, tick count, bit shift.
module pwbd_core #(
    parameter int unsigned BITS_PER_WORD = 8,
    parameter int unsigned COUNT_WIDTH   = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step,
    input  logic                                  level,
    input  logic [pwbd_pkg::THRESH_WIDTH-1:0]     threshold,
    output pwbd_pkg::pwbd_result_t                result
);
    import pwbd_pkg::*;

    localparam int unsigned CNT_W = $clog2(BITS_PER_WORD + 1);
    localparam int unsigned CMP_W = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS_PER_WORD - 1);

    logic                   prev_level_reg, prev_level_next;
    logic [COUNT_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [COUNT_WIDTH-1:0] high_time_reg, high_time_next;
    logic [DATA_WIDTH-1:0]  shift_bits_reg, shift_bits_next;
    logic [CNT_W-1:0]       bit_count_reg, bit_count_next;

    logic                   rising;
    logic                   falling;
    logic                   new_bit;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [DATA_WIDTH-1:0]  shifted;

    // Edge detect and bit decision
    assign rising   = !prev_level_reg && level;
    assign falling  = prev_level_reg && !level;
    assign new_bit  = !(CMP_W'(high_time_reg) > CMP_W'(threshold));
    assign shifted  = {shift_bits_reg[DATA_WIDTH-2:0], new_bit};
    // saturating increment
    assign tick_inc = (&tick_count_reg) ? tick_count_reg : tick_count_reg + 1'b1;

    // Result of this sample
    always_comb
    begin
        result.emit = rising && (bit_count_reg == LAST_BIT);
        result.data = shifted;
    end

    // Next state
    always_comb
    begin
        prev_level_next = level;
        tick_count_next = tick_count_reg;
        high_time_next  = high_time_reg;
        shift_bits_next = shift_bits_reg;
        bit_count_next  = bit_count_reg;
        if (rising)
        begin
            tick_count_next = '0;
            if (result.emit)
            begin
                shift_bits_next = '0;
                bit_count_next  = '0;
            end
            else
            begin
                shift_bits_next = shifted;
                bit_count_next  = bit_count_reg + 1'b1;
            end
        end
        else
        begin
            tick_count_next = tick_inc;
            if (falling)
            begin
                high_time_next = tick_inc;
            end
        end
    end

    // State registers, updated once per consumed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b0;
            tick_count_reg <= '0;
            high_time_reg  <= '0;
            shift_bits_reg <= '0;
            bit_count_reg  <= '0;
        end
        else if (step)
        begin
            prev_level_reg <= prev_level_next;
            tick_count_reg <= tick_count_next;
            high_time_reg  <= high_time_next;
            shift_bits_reg <= shift_bits_next;
            bit_count_reg  <= bit_count_next;
        end
    end

endmodule

[tb/pulse_width_bit_decoder_tb.sv]
// Testbench for the pulse-width bit decoder: pulse trains in, decoded bytes checked.
`timescale 1ns / 1ps

module pulse_width_bit_decoder_tb;
    import pwbd_pkg::*;

    localparam int unsigned WORD_BITS   = 8;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned PHASE_ITEMS = 165;

    // Decoder prediction and byte checking
    class byte_scoreboard;
        logic [THRESH_WIDTH-1:0] threshold;
        bit                      prev_level;
        bit [31:0]               tick_count;
        bit [31:0]               high_ticks;
        bit [DATA_WIDTH-1:0]     shift_bits;
        int unsigned             bits_in_word;
        bit [DATA_WIDTH-1:0]     expected_bytes[$];
        int unsigned             bytes_predicted;
        int unsigned             bytes_checked;
        int unsigned             errors;

        function new();
            threshold       = THRESH_RESET;
            prev_level      = 1'b0;
            tick_count      = '0;
            high_ticks      = '0;
            shift_bits      = '0;
            bits_in_word    = 0;
            bytes_predicted = 0;
            bytes_checked   = 0;
            errors          = 0;
        endfunction

        // Advance the decoder by one accepted line sample
        function void note_sample(bit level);
            bit rise;
            bit fall;
            rise = !prev_level && level;
            fall = prev_level && !level;
            prev_level = level;
            if (rise)
            begin
                // a long captured pulse decodes as 0, a short one as 1
                shift_bits = {shift_bits[DATA_WIDTH-2:0], (high_ticks > threshold) ? 1'b0 : 1'b1};
                tick_count = '0;
                bits_in_word++;
                if (bits_in_word == WORD_BITS)
                begin
                    expected_bytes.push_back(shift_bits);
                    bytes_predicted++;
                    shift_bits   = '0;
                    bits_in_word = 0;
                end
            end
            else
            begin
                if (tick_count != '1)
                    tick_count++;
                if (fall)
                    high_ticks = tick_count;
            end
        endfunction

        // Compare one accepted byte with the oldest prediction
        function void check_byte(logic [DATA_WIDTH-1:0] got, logic got_last);
            bit [DATA_WIDTH-1:0] want;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte, expected none, actual 0x%02h", $time, got);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (got !== want)
            begin
                $display("%0t: data_byte mismatch, expected 0x%02h, actual 0x%02h",
                         $time, want, got);
                errors++;
            end
            if (got_last !== 1'b1)
            begin
                $display("%0t: last mismatch, expected 1, actual %b", $time, got_last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    sample_valid = 1'b0;
    logic                    sample_ready;
    logic                    line_level   = 1'b0;
    logic                    byte_valid;
    logic                    byte_ready   = 1'b0;
    logic [DATA_WIDTH-1:0]   data_byte;
    logic                    last;
    logic                    cfg_we       = 1'b0;
    logic [THRESH_WIDTH-1:0] cfg_wdata    = '0;

    byte_scoreboard          sb = new();
    bit                      tx_no_gaps;
    bit                      rx_no_stalls;
    int unsigned             rx_hold_cycles;
    int unsigned             samples_sent;
    int unsigned             settings_used;
    int unsigned             input_stall_cycles;
    int unsigned             cycle_count;
    logic [THRESH_WIDTH-1:0] thresh_list[10];
    int unsigned             phase;

    pulse_width_bit_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .line_level   (line_level),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .data_byte    (data_byte),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog and input backpressure count
    always @(posedge clk)
    begin
        cycle_count++;
        if (sample_valid && !sample_ready)
            input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d bytes outstanding",
                     $time, cycle_count, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // One line sample request, after a random gap when gaps are enabled
    task automatic send_sample(input bit level);
        int unsigned gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        line_level   <= level;
        do @(posedge clk); while (!sample_ready);
        sb.note_sample(level);
        samples_sent++;
    endtask

    task automatic send_pulse(input int unsigned high_len, input int unsigned low_len);
        repeat (high_len) send_sample(1'b1);
        repeat (low_len) send_sample(1'b0);
    endtask

    // Drain: sender quiet until every byte is back, then let the pipeline empty
    task automatic settle();
        sample_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THRESH_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.threshold = value;
        settings_used++;
    endtask

    // Mostly well-formed pulse trains, near the threshold when it is small, some line noise
    task automatic run_phase(input int unsigned budget);
        int unsigned first;
        int unsigned high_len;
        int unsigned noise_len;
        first = samples_sent;
        while (samples_sent - first < budget)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                if (sb.threshold <= 20 && $urandom_range(0, 3) != 0)
                    high_len = sb.threshold + $urandom_range(0, 2) - 1;
                else
                    high_len = $urandom_range(1, 12);
                if (high_len == 0 || high_len > 32)
                    high_len = 1;
                send_pulse(high_len, $urandom_range(1, 3));
            end
            else
            begin
                noise_len = $urandom_range(1, 6);
                repeat (noise_len) send_sample(1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Byte sink: random stall once a byte is waiting, a long hold when one is requested
    initial
    begin : byte_sink
        int unsigned stall;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (rx_hold_cycles != 0)
            begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            else if (rx_no_stalls)
                stall = 0;
            else
                stall = $urandom_range(0, 15);
            if (stall != 0)
            begin
                byte_ready <= 1'b0;
                do @(posedge clk); while (!byte_valid);
                repeat (stall - 1) @(posedge clk);
            end
            byte_ready <= 1'b1;
            do @(posedge clk); while (!byte_valid);
            sb.check_byte(data_byte, last);
        end
    end

    // Main sequence
    initial
    begin
        thresh_list[0] = '0;
        thresh_list[1] = 32'd1;
        thresh_list[2] = '1;
        thresh_list[3] = 32'd3;
        thresh_list[4] = 32'd2;
        thresh_list[5] = $urandom_range(0, 15);
        thresh_list[6] = 32'd7;
        thresh_list[7] = $urandom;
        thresh_list[8] = 32'd5;
        thresh_list[9] = $urandom_range(0, 20);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset threshold: line high on the first sample, short pulses all decode as 1
        tx_no_gaps = 1'b1;
        send_pulse(1, 1);
        send_pulse(4, 2);
        send_pulse(6, 1);
        send_pulse(2, 1);
        send_pulse(1, 3);
        send_pulse(3, 2);
        send_pulse(1, 1);
        send_pulse(2, 1);
        send_pulse(1, 1);
        settle();

        // Random phases over several thresholds, extremes included
        for (phase = 0; phase < 10; phase++)
        begin
            settle();
            write_threshold(thresh_list[phase % 10]);
            tx_no_gaps   = (phase % 3 == 1);
            rx_no_stalls = (phase % 4 == 2);
            if (phase == 4)
            begin
                // sink holds off while samples keep coming
                tx_no_gaps     = 1'b1;
                rx_no_stalls   = 1'b0;
                rx_hold_cycles = 400;
            end
            run_phase(PHASE_ITEMS);
        end

        settle();
        repeat (8) @(posedge clk);

        $display("Decoded %0d bytes from %0d line samples across %0d threshold writes",
                 sb.bytes_checked, samples_sent, settings_used);
        $display("Sample input was held off for %0d cycles by byte backpressure",
                 input_stall_cycles);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
src/pwbd_pkg.sv
src/pwbd_core.sv
src/pulse_width_bit_decoder.sv
tb/pulse_width_bit_decoder_tb.sv
